@@ src/ps2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2d_pkg
// Shared types, constants and the extended-code translation table of the
// PS/2 Set 2 scan code decoder.
// ----------------------------------------------------------------------------
package ps2d_pkg;

    // Scan byte values with a special meaning
    localparam logic [7:0] SC_E0       = 8'hE0;
    localparam logic [7:0] SC_E1       = 8'hE1;
    localparam logic [7:0] SC_F0       = 8'hF0;
    localparam logic [7:0] SC_LSHIFT   = 8'h12;
    localparam logic [7:0] SC_RSHIFT   = 8'h59;
    localparam logic [7:0] SC_CTRL     = 8'h14;
    localparam logic [7:0] SC_NUMLOCK  = 8'h77;
    localparam logic [7:0] SC_F7       = 8'h83;
    localparam logic [7:0] SC_SYSRQ    = 8'h84;

    // Key codes that the two high plain codes map to
    localparam logic [6:0] KC_F7       = 7'h02;
    localparam logic [6:0] KC_SYSRQ    = 7'h7F;

    // Prefix parser states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_F0         = 9'b000000010,
        ST_E0         = 9'b000000100,
        ST_E0F0       = 9'b000001000,
        ST_E1         = 9'b000010000,
        ST_E1_14      = 9'b000100000,
        ST_E1F0       = 9'b001000000,
        ST_E1F0_14    = 9'b010000000,
        ST_E1F0_14_F0 = 9'b100000000
    } state_t;

    // One key event out of the parser
    typedef struct packed {
        logic       valid;
        logic [6:0] key_code;
        logic       pressed;
    } key_evt_t;

    // Extended code translation; zero means no key
    function automatic logic [6:0] ext_lookup(input logic [6:0] idx);
        logic [6:0] code;
        case (idx)
            7'h10:   code = 7'h08;
            7'h11:   code = 7'h0F;
            7'h14:   code = 7'h19;
            7'h15:   code = 7'h18;
            7'h18:   code = 7'h10;
            7'h1F:   code = 7'h17;
            7'h20:   code = 7'h18;
            7'h21:   code = 7'h65;
            7'h23:   code = 7'h6F;
            7'h27:   code = 7'h1F;
            7'h28:   code = 7'h20;
            7'h2B:   code = 7'h50;
            7'h2F:   code = 7'h27;
            7'h30:   code = 7'h28;
            7'h32:   code = 7'h6E;
            7'h34:   code = 7'h08;
            7'h37:   code = 7'h5F;
            7'h38:   code = 7'h30;
            7'h3A:   code = 7'h38;
            7'h3B:   code = 7'h10;
            7'h3F:   code = 7'h57;
            7'h40:   code = 7'h40;
            7'h48:   code = 7'h48;
            7'h4A:   code = 7'h60;
            7'h4D:   code = 7'h20;
            7'h50:   code = 7'h28;
            7'h5A:   code = 7'h62;
            7'h5E:   code = 7'h50;
            7'h69:   code = 7'h5C;
            7'h6B:   code = 7'h53;
            7'h6C:   code = 7'h2F;
            7'h70:   code = 7'h39;
            7'h71:   code = 7'h37;
            7'h72:   code = 7'h3F;
            7'h74:   code = 7'h47;
            7'h75:   code = 7'h4F;
            7'h77:   code = 7'h48;
            7'h7A:   code = 7'h56;
            7'h7C:   code = 7'h7F;
            7'h7D:   code = 7'h5E;
            7'h7E:   code = 7'h48;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

@@ src/ps2d_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2d_if
// Valid/ready channels of the decoder: scan bytes in, key events out.
// ----------------------------------------------------------------------------
interface ps2d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2d_key_if;
    logic       valid;
    logic       ready;
    logic [6:0] key_code;
    logic       pressed;

    modport source (output valid, output key_code, output pressed, input ready);
    modport sink   (input valid, input key_code, input pressed, output ready);
endinterface

@@ src/ps2d_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2d_parser
// Prefix parser: next state and optional key event for one scan byte.
// ----------------------------------------------------------------------------
module ps2d_parser
    import ps2d_pkg::*;
(
    input  state_t     state,
    input  logic [7:0] scan_byte,
    output state_t     state_next,
    output key_evt_t   evt
);

    logic       high_bit;
    logic       fake_shift;
    logic [6:0] ext_code;
    logic [6:0] plain_code;
    logic       plain_ok;

    // Plain code mapping, shared by make and break
    always_comb
    begin
        high_bit   = scan_byte[7];
        fake_shift = (scan_byte == SC_LSHIFT) || (scan_byte == SC_RSHIFT);
        ext_code   = ext_lookup(scan_byte[6:0]);
        plain_ok   = 1'b1;
        if (scan_byte == SC_F7)
        begin
            plain_code = KC_F7;
        end
        else if (scan_byte == SC_SYSRQ)
        begin
            plain_code = KC_SYSRQ;
        end
        else
        begin
            plain_code = scan_byte[6:0];
            plain_ok   = !high_bit;
        end
    end

    // State transitions and event selection
    always_comb
    begin
        state_next   = ST_IDLE;
        evt.valid    = 1'b0;
        evt.key_code = ext_code;
        evt.pressed  = 1'b1;
        case (state)
            ST_IDLE:
            begin
                if (scan_byte == SC_E0)
                begin
                    state_next = ST_E0;
                end
                else if (scan_byte == SC_F0)
                begin
                    state_next = ST_F0;
                end
                else if (scan_byte == SC_E1)
                begin
                    state_next = ST_E1;
                end
                else
                begin
                    evt.valid    = plain_ok;
                    evt.key_code = plain_code;
                end
            end
            ST_F0:
            begin
                evt.valid    = plain_ok;
                evt.key_code = plain_code;
                evt.pressed  = 1'b0;
            end
            ST_E0:
            begin
                if (scan_byte == SC_F0)
                begin
                    state_next = ST_E0F0;
                end
                else
                begin
                    evt.valid = !fake_shift && !high_bit && (ext_code != 7'h00);
                end
            end
            ST_E0F0:
            begin
                evt.valid   = !fake_shift && !high_bit && (ext_code != 7'h00);
                evt.pressed = 1'b0;
            end
            ST_E1:
            begin
                if (scan_byte == SC_CTRL)
                begin
                    state_next = ST_E1_14;
                end
                else if (scan_byte == SC_F0)
                begin
                    state_next = ST_E1F0;
                end
            end
            ST_E1_14:
            begin
                evt.valid = (scan_byte == SC_NUMLOCK);
            end
            ST_E1F0:
            begin
                if (scan_byte == SC_CTRL)
                begin
                    state_next = ST_E1F0_14;
                end
            end
            ST_E1F0_14:
            begin
                if (scan_byte == SC_F0)
                begin
                    state_next = ST_E1F0_14_F0;
                end
            end
            ST_E1F0_14_F0:
            begin
                evt.valid   = (scan_byte == SC_NUMLOCK);
                evt.pressed = 1'b0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/ps2_set2_scancode_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_set2_scancode_decoder
// PS/2 Set 2 scan code decoder: raw keyboard bytes in, key events out.
// ----------------------------------------------------------------------------
// Takes one scan byte per cycle while input ready is high and reports each
// finished key as a 7-bit key code with a make/break flag; prefix bytes (E0,
// F0, E1 and the leading bytes of the Pause sequence) and discarded codes
// produce nothing. A byte is registered on entry, decoded combinationally
// against the parser state and its event lands in the output register; a
// new byte is taken every cycle unless the output stalls. Input ready drops
// only while an event waits in the output register, the next byte also
// makes one and the sink holds off.
// ----------------------------------------------------------------------------
module ps2_set2_scancode_decoder
    import ps2d_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    ps2d_byte_if.sink      scan_in,
    ps2d_key_if.source     key_out
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s2_valid_reg;
    logic       s2_valid_next;
    logic [6:0] s2_code_reg;
    logic       s2_pressed_reg;
    state_t     state_reg;
    state_t     state_next;
    key_evt_t   evt;
    logic       advance;

    // Decode of the registered byte
    ps2d_parser u_parser (
        .state      (state_reg),
        .scan_byte  (s1_byte_reg),
        .state_next (state_next),
        .evt        (evt)
    );

    // Handshake: the input stage moves on unless its event has nowhere to go
    always_comb
    begin
        advance       = s1_valid_reg && (!evt.valid || !s2_valid_reg || key_out.ready);
        scan_in.ready = !s1_valid_reg || advance;
        s1_valid_next = scan_in.ready ? scan_in.valid : s1_valid_reg;
        if (advance && evt.valid)
        begin
            s2_valid_next = 1'b1;
        end
        else if (key_out.ready)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            state_reg    <= ST_IDLE;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (scan_in.ready && scan_in.valid)
        begin
            s1_byte_reg <= scan_in.scan_byte;
        end
        if (advance && evt.valid)
        begin
            s2_code_reg    <= evt.key_code;
            s2_pressed_reg <= evt.pressed;
        end
    end

    assign key_out.valid    = s2_valid_reg;
    assign key_out.key_code = s2_code_reg;
    assign key_out.pressed  = s2_pressed_reg;

endmodule

@@ src/ps2d_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2d_checker
// Port-level assertions for the scan code decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ps2d_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] out_key_code,
    input logic       out_pressed
);

    // A pending event is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("key event dropped while stalled");

    // Stalled event keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_key_code) && $stable(out_pressed))
        else $error("key event changed while stalled");

    // Input back-pressure only comes from a stalled output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // No event shows while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("key event during reset");

endmodule

bind ps2_set2_scancode_decoder ps2d_checker u_ps2d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (scan_in.ready),
    .out_valid    (key_out.valid),
    .out_ready    (key_out.ready),
    .out_key_code (key_out.key_code),
    .out_pressed  (key_out.pressed)
);
